// ===== rtl/hilb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hilb_pkg;

  // Largest supported curve order; the grid side is 2^order.
  localparam int MAX_ORDER = 10;

  // Field widths.
  localparam int ORDER_W = 4;
  localparam int IDX_W   = 2 * MAX_ORDER;
  localparam int COORD_W = MAX_ORDER;
  localparam int SHIFT_W = $clog2(IDX_W + 1);

  // Stages from an accepted start to the done strobe:
  // one input stage, one cell per level, one output stage.
  localparam int LATENCY = MAX_ORDER + 2;

  // One beat as it moves down the row of cells.
  typedef struct packed {
    logic               valid;
    logic               err;
    logic [ORDER_W-1:0] order;
    logic [IDX_W-1:0]   index;
    logic               inv;    // remaining index is reflected
    logic               swap;   // outer transform swaps x and y
    logic               cx;     // outer transform complements x
    logic               cy;     // outer transform complements y
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cell_beat_t;

  // Clamp the configured order into the supported range.
  function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] o);
    logic [ORDER_W-1:0] r;
    r = o;
    if (r == '0) r = ORDER_W'(1);
    if (r > ORDER_W'(MAX_ORDER)) r = ORDER_W'(MAX_ORDER);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hilb_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hilb_cell
  import hilb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [ORDER_W-1:0] level,
  input  wire cell_beat_t         beat_in,
  output cell_beat_t              beat_out
);

  // Quadrant codes at one level of the curve.
  typedef enum logic [1:0] {
    QUAD_ENTRY = 2'd0,
    QUAD_NEXT  = 2'd1,
    QUAD_RIGHT = 2'd2,
    QUAD_EXIT  = 2'd3
  } quad_t;

  cell_beat_t         beat_next;
  logic [SHIFT_W-1:0] shift_lo;
  logic [1:0]         raw;
  quad_t              quad;
  logic               bx;
  logic               by;
  logic               ox;
  logic               oy;
  logic               active;
  logic [ORDER_W-1:0] bit_pos;

  assign active   = beat_in.valid && !beat_in.err && (level <= beat_in.order);
  assign shift_lo = SHIFT_W'({level, 1'b0} - 2);
  assign bit_pos  = level - ORDER_W'(1);
  assign raw      = 2'(beat_in.index >> shift_lo);
  assign quad     = quad_t'(raw ^ {2{beat_in.inv}});

  // Pick this level's quadrant, place its bit through the outer transform,
  // and fold the quadrant's own reflection into the transform for lower levels.
  always_comb begin
    beat_next = beat_in;
    bx = 1'b0;
    by = 1'b0;
    case (quad)
      QUAD_ENTRY: begin
        bx = 1'b0;
        by = 1'b1;
      end
      QUAD_NEXT: begin
        bx = 1'b0;
        by = 1'b0;
      end
      QUAD_RIGHT: begin
        bx = 1'b1;
        by = 1'b0;
      end
      QUAD_EXIT: begin
        bx = 1'b1;
        by = 1'b1;
      end
      default: begin
        bx = 1'b0;
        by = 1'b0;
      end
    endcase
    ox = (beat_in.swap ? by : bx) ^ beat_in.cx;
    oy = (beat_in.swap ? bx : by) ^ beat_in.cy;
    if (active) begin
      beat_next.x = beat_in.x | (COORD_W'(ox) << bit_pos);
      beat_next.y = beat_in.y | (COORD_W'(oy) << bit_pos);
      if (quad == QUAD_ENTRY) begin
        beat_next.inv  = !beat_in.inv;
        beat_next.swap = !beat_in.swap;
        if (beat_in.swap) begin
          beat_next.cy = !beat_in.cy;
        end else begin
          beat_next.cx = !beat_in.cx;
        end
      end else if (quad == QUAD_EXIT) begin
        beat_next.swap = !beat_in.swap;
      end
    end
  end

  // Stage register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else begin
      beat_out <= beat_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hilbert_index_to_xy_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Hilbert curve index to pixel coordinate converter.
// Input: raise start with curve_index; the beat is taken at a clock edge where
// start is high and busy is low. busy is set by reset and cleared by the first
// clock edge without reset, so from then on a new index can be taken on every clock.
// Output: done strobes for one cycle with pixel_x, pixel_y and index_error.
// An index at or beyond 4^order sets index_error and gives zero coordinates.
// A beat passes an input stage, one cell per curve level from the top level
// down, and an output stage. Throughput is one beat per clock, set by the row
// of cells, each holding one beat in flight.
// Configuration: cfg_we writes cfg_data into the curve order register
// (reset value 10); order zero acts as one, orders above the maximum saturate.
// Write it only while no beat is in flight.
// Reset is synchronous and empties the pipeline; beats in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
module hilbert_index_to_xy_unit
  import hilb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [IDX_W-1:0]   curve_index,
  input  wire logic               cfg_we,
  input  wire logic [ORDER_W-1:0] cfg_data,
  output logic                    done,
  output logic [COORD_W-1:0]      pixel_x,
  output logic [COORD_W-1:0]      pixel_y,
  output logic                    index_error
);

  logic [ORDER_W-1:0] curve_order;
  logic [ORDER_W-1:0] order_now;
  logic               accept;
  cell_beat_t         entry_beat;
  cell_beat_t         chain [MAX_ORDER+1];

  assign order_now = eff_order(curve_order);
  assign accept    = start && !busy;

  // Configuration register and the busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order <= ORDER_W'(MAX_ORDER);
      busy        <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        curve_order <= cfg_data;
      end
    end
  end

  // Input stage: capture the index and flag out-of-range positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_beat.valid <= 1'b0;
    end else begin
      entry_beat.valid <= accept;
      entry_beat.err   <= (curve_index >> {order_now, 1'b0}) != '0;
      entry_beat.order <= order_now;
      entry_beat.index <= curve_index;
      entry_beat.inv   <= 1'b0;
      entry_beat.swap  <= 1'b0;
      entry_beat.cx    <= 1'b0;
      entry_beat.cy    <= 1'b0;
      entry_beat.x     <= '0;
      entry_beat.y     <= '0;
    end
  end

  assign chain[0] = entry_beat;

  // Row of cells, the first one handling the top curve level.
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
    hilb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .level    (ORDER_W'(MAX_ORDER - k)),
      .beat_in  (chain[k]),
      .beat_out (chain[k+1])
    );
  end

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done        <= chain[MAX_ORDER].valid;
      index_error <= chain[MAX_ORDER].err;
      pixel_x     <= chain[MAX_ORDER].err ? '0 : chain[MAX_ORDER].x;
      pixel_y     <= chain[MAX_ORDER].err ? '0 : chain[MAX_ORDER].y;
    end
  end

  // Every result traces back to an accepted beat.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done without a matching accepted beat");

  // Out-of-range indexes give zero coordinates.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && index_error) |-> (pixel_x == '0 && pixel_y == '0))
    else $error("error result with nonzero coordinates");

  // Valid coordinates lie inside the configured grid.
  a_in_grid: assert property (@(posedge clk) disable iff (rst)
    (done && !index_error) |->
      ((pixel_x >> order_now) == '0 && (pixel_y >> order_now) == '0))
    else $error("coordinate outside the grid");

  // Once out of reset busy stays low, so a beat with start high is taken on every clock.
  a_not_busy: assert property (@(posedge clk) disable iff (rst)
    !rst |=> !busy)
    else $error("busy outside reset recovery");

endmodule

`default_nettype wire
